@@ design/mik_pkg.sv @@
// Shared widths, wheel indexes, register indexes and pipeline word types for the
// mecanum inverse kinematics block. No dependencies.
`timescale 1ns / 1ps

package mik_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int VEL_W        = 16;   // body velocity fields
    localparam int CIRC_W       = 12;   // wheel circumference register
    localparam int DIST_W       = 12;   // track width and wheel base registers
    localparam int LIM_W        = 15;   // rpm limit register
    localparam int RPM_W        = 16;   // wheel speed outputs
    localparam int SPAN_W       = DIST_W + 1;
    localparam int SUM_W        = VEL_W + 1;
    localparam int LIN_W        = 28;   // 2000 * (vx +/- vy)
    localparam int TURN_W       = 29;   // yaw_rate * (track + base)
    localparam int MIX_W        = 30;   // linear term +/- turn term
    localparam int MAG_W        = 31;   // 3 * |mix|
    localparam int DIV_W        = 19;   // 100 * circumference
    localparam int QUO_W        = 15;   // quotient bits below the saturation point
    localparam int REM_W        = DIV_W + QUO_W;
    localparam int STEP_PER_STG = 3;
    localparam int DIV_STAGES   = QUO_W / STEP_PER_STG;

    localparam int RPM_SCALE    = 2000;
    localparam int DIV_SCALE    = 100;

    localparam int WHEEL_FL     = 0;
    localparam int WHEEL_FR     = 1;
    localparam int WHEEL_RL     = 2;
    localparam int WHEEL_RR     = 3;

    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIRC  = 8'd0,
        REG_TRACK = 8'd1,
        REG_BASE  = 8'd2,
        REG_LIMIT = 8'd3
    } cfg_reg_t;

    // Word handed from the mixing pipeline to the divider.
    typedef struct packed {
        logic                                valid;
        logic [NUM_WHEELS-1:0]               neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0]    mag;
    } mik_dividend_t;

    // Word handed from the divider to the output clamp.
    typedef struct packed {
        logic                                valid;
        logic [NUM_WHEELS-1:0]               neg;
        logic [NUM_WHEELS-1:0]               ovf;
        logic [NUM_WHEELS-1:0][QUO_W-1:0]    quo;
    } mik_quot_t;

endpackage

@@ design/mik_mix.sv @@
// Front half of the pipeline: forms the four signed wheel sums and their scaled magnitudes.
// Depends on mik_pkg.
`timescale 1ns / 1ps

module mik_mix
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [mik_pkg::VEL_W-1:0]        vel_x,
    input  logic [mik_pkg::VEL_W-1:0]        vel_y,
    input  logic [mik_pkg::VEL_W-1:0]        yaw_rate,
    input  logic [mik_pkg::SPAN_W-1:0]       span,
    output mik_pkg::mik_dividend_t           dvd
);
    import mik_pkg::*;

    localparam logic [LIN_W-1:0] LIN_SCALE = LIN_W'(RPM_SCALE);

    logic                              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [VEL_W-1:0]                  vx_reg, vy_reg, wz_reg;
    logic [SUM_W-1:0]                  sum_next, dif_next, sum_reg, dif_reg;
    logic [TURN_W-1:0]                 turn_next, turn_reg, turn3_reg;
    logic [LIN_W-1:0]                  lsum_next, ldif_next, lsum_reg, ldif_reg;
    logic [NUM_WHEELS-1:0][MIX_W-1:0]  mix_next, mix_reg;
    logic [NUM_WHEELS-1:0]             neg_next, neg_reg;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag_next, mag_reg;

    // Stage 2: pair the linear velocities and form the turn term.
    assign sum_next  = {vx_reg[VEL_W-1], vx_reg} + {vy_reg[VEL_W-1], vy_reg};
    assign dif_next  = {vx_reg[VEL_W-1], vx_reg} - {vy_reg[VEL_W-1], vy_reg};
    assign turn_next = {{(TURN_W-VEL_W){wz_reg[VEL_W-1]}}, wz_reg}
                     * {{(TURN_W-SPAN_W){1'b0}}, span};

    // Stage 3: scale the linear terms so that they share the turn term's units.
    assign lsum_next = {{(LIN_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg} * LIN_SCALE;
    assign ldif_next = {{(LIN_W-SUM_W){dif_reg[SUM_W-1]}}, dif_reg} * LIN_SCALE;

    // Stage 4: the four wheel combinations.
    always_comb
    begin
        logic [MIX_W-1:0] ls, ld, tn;
        ls = {{(MIX_W-LIN_W){lsum_reg[LIN_W-1]}}, lsum_reg};
        ld = {{(MIX_W-LIN_W){ldif_reg[LIN_W-1]}}, ldif_reg};
        tn = {{(MIX_W-TURN_W){turn3_reg[TURN_W-1]}}, turn3_reg};
        mix_next[WHEEL_FL] = ld - tn;
        mix_next[WHEEL_FR] = ls + tn;
        mix_next[WHEEL_RL] = ls - tn;
        mix_next[WHEEL_RR] = ld + tn;
    end

    // Stage 5: sign and magnitude, the magnitude times three.
    always_comb
    begin
        logic [MIX_W-1:0] abs_v;
        logic [MAG_W-1:0] ext;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            neg_next[w] = mix_reg[w][MIX_W-1];
            abs_v       = neg_next[w] ? (~mix_reg[w] + 1'b1) : mix_reg[w];
            ext         = {1'b0, abs_v};
            mag_next[w] = (ext << 1) + ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg    <= vel_x;
        vy_reg    <= vel_y;
        wz_reg    <= yaw_rate;
        sum_reg   <= sum_next;
        dif_reg   <= dif_next;
        turn_reg  <= turn_next;
        lsum_reg  <= lsum_next;
        ldif_reg  <= ldif_next;
        turn3_reg <= turn_reg;
        mix_reg   <= mix_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
    end

    assign dvd.valid = v5_reg;
    assign dvd.neg   = neg_reg;
    assign dvd.mag   = mag_reg;

    // Every dividend word comes from a command that has passed through the mixing stages.
    a_mix_latency: assert property (@(posedge clk) disable iff (!rst_n)
        dvd.valid |-> $past(in_valid, 5))
        else $error("mix stage produced a word without a matching command");

endmodule

@@ design/mik_div.sv @@
// Pipelined restoring divider for the four wheel magnitudes, three quotient bits per stage.
// Depends on mik_pkg.
`timescale 1ns / 1ps

module mik_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mik_pkg::DIV_W-1:0]     divisor,
    input  mik_pkg::mik_dividend_t        dvd,
    output mik_pkg::mik_quot_t            quo
);
    import mik_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_step_t;

    // Runs a few restoring steps, the quotient bits entering from the right.
    function automatic div_step_t div_steps(input logic [MAG_W-1:0] rem_in,
                                            input logic [QUO_W-1:0] quo_in,
                                            input logic [DIV_W-1:0] dsr,
                                            input int               top_bit);
        div_step_t        res;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] wide;
        logic             hit;
        res.rem = rem_in;
        res.quo = quo_in;
        for (int k = 0; k < STEP_PER_STG; k++)
        begin
            shifted = REM_W'(dsr) << (top_bit - k);
            wide    = REM_W'(res.rem);
            hit     = (wide >= shifted);
            if (hit)
            begin
                res.rem = MAG_W'(wide - shifted);
            end
            res.quo = {res.quo[QUO_W-2:0], hit};
        end
        return res;
    endfunction

    logic                             vld_reg [0:DIV_STAGES];
    logic [NUM_WHEELS-1:0]            neg_reg [0:DIV_STAGES];
    logic [NUM_WHEELS-1:0]            ovf_reg [0:DIV_STAGES];
    logic [NUM_WHEELS-1:0][MAG_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [NUM_WHEELS-1:0][QUO_W-1:0] quo_reg [1:DIV_STAGES];
    logic [NUM_WHEELS-1:0]            ovf_next;

    // A quotient of 2^QUO_W or more lies above any limit the register can hold.
    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            ovf_next[w] = (REM_W'(dvd.mag[w]) >= {divisor, {QUO_W{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= dvd.valid;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= dvd.mag;
        neg_reg[0] <= dvd.neg;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        localparam int TOP_BIT = QUO_W - 1 - (s - 1) * STEP_PER_STG;
        div_step_t st [NUM_WHEELS];

        if (s == 1)
        begin : g_first
            always_comb
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    st[w] = div_steps(rem_reg[0][w], '0, divisor, TOP_BIT);
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    st[w] = div_steps(rem_reg[s-1][w], quo_reg[s-1][w], divisor, TOP_BIT);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                quo_reg[s][w] <= st[w].quo;
            end
        end

        if (s < DIV_STAGES)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    rem_reg[s][w] <= st[w].rem;
                end
            end
        end
    end

    assign quo.valid = vld_reg[DIV_STAGES];
    assign quo.neg   = neg_reg[DIV_STAGES];
    assign quo.ovf   = ovf_reg[DIV_STAGES];
    assign quo.quo   = quo_reg[DIV_STAGES];

    // Each quotient word comes from a dividend that passed the input register and every stage.
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        quo.valid |-> $past(dvd.valid, DIV_STAGES + 1))
        else $error("divider produced a word without a matching dividend");

endmodule

@@ design/mecanum_inverse_kinematics.sv @@
// Top level of the mecanum inverse kinematics block: configuration registers, command
// handshake, output clamp. Depends on mik_pkg, mik_mix and mik_div.
`timescale 1ns / 1ps
// Pipeline: a command taken at a clock edge passes five mixing stages, the divider's input register
// and its stages and one clamp, and is answered by a result_valid strobe that carries its word.
// Throughput: one command every cycle once busy is low; the fully pipelined datapath and divider take a new
// word each cycle, and the receiver cannot stall, so busy stays low once it drops after reset.
// Reset: rst_n clears every valid bit and loads the register defaults
// (circumference 314, track 300, base 300, limit 330); busy is high until rst_n is released and the clock runs.

module mecanum_inverse_kinematics
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [mik_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [mik_pkg::VEL_W-1:0]  vel_y,
    input  logic signed [mik_pkg::VEL_W-1:0]  yaw_rate,
    output logic                              result_valid,
    output logic signed [mik_pkg::RPM_W-1:0]  front_left_rpm,
    output logic signed [mik_pkg::RPM_W-1:0]  front_right_rpm,
    output logic signed [mik_pkg::RPM_W-1:0]  rear_left_rpm,
    output logic signed [mik_pkg::RPM_W-1:0]  rear_right_rpm,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mik_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mik_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mik_pkg::*;

    // Configuration registers: the user must write them only while no command is in flight,
    // which the block does not enforce; the datapath reads them where needed, the circumference via div_reg.
    logic [CIRC_W-1:0]  circ_reg,  circ_next;
    logic [DIST_W-1:0]  track_reg, track_next;
    logic [DIST_W-1:0]  base_reg,  base_next;
    logic [LIM_W-1:0]   limit_reg, limit_next;
    logic [DIV_W-1:0]   div_reg,   div_next;
    logic               busy_reg;
    logic               in_valid;
    logic [SPAN_W-1:0]  span;

    mik_dividend_t      dvd;
    mik_quot_t          quo;

    logic                             result_valid_reg;
    logic [NUM_WHEELS-1:0][RPM_W-1:0] rpm_reg, rpm_next;
    logic                             out_in_range;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign in_valid  = start && !busy_reg;

    // Register decoder. Indexes outside the list are dropped; data bits above a
    // register's width are ignored.
    always_comb
    begin
        circ_next  = circ_reg;
        track_next = track_reg;
        base_next  = base_reg;
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CIRC:  circ_next  = cfg_data[CIRC_W-1:0];
                REG_TRACK: track_next = cfg_data[DIST_W-1:0];
                REG_BASE:  base_next  = cfg_data[DIST_W-1:0];
                REG_LIMIT: limit_next = cfg_data[LIM_W-1:0];
                default:   ;
            endcase
        end
    end

    // The full divisor is 1000 * circumference and every numerator carries a factor
    // of 30; both are divided by ten, leaving 100 * circumference against 3 * |mix|.
    // A circumference of zero is treated as one millimeter.
    always_comb
    begin
        logic [CIRC_W-1:0] circ_eff;
        circ_eff = (circ_reg == '0) ? CIRC_W'(1) : circ_reg;
        div_next = DIV_W'(circ_eff) * DIV_W'(DIV_SCALE);
    end

    assign span = SPAN_W'(track_reg) + SPAN_W'(base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg  <= CIRC_W'(314);
            track_reg <= DIST_W'(300);
            base_reg  <= DIST_W'(300);
            limit_reg <= LIM_W'(330);
            busy_reg  <= 1'b1;
        end
        else
        begin
            circ_reg  <= circ_next;
            track_reg <= track_next;
            base_reg  <= base_next;
            limit_reg <= limit_next;
            busy_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    mik_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .yaw_rate (yaw_rate),
        .span     (span),
        .dvd      (dvd)
    );

    mik_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .divisor (div_reg),
        .dvd     (dvd),
        .quo     (quo)
    );

    // Clamp stage. The quotient is the truncated magnitude; an overflowed quotient is
    // above every possible limit. The sign goes back on after clamping, which keeps
    // the result truncated toward zero.
    always_comb
    begin
        logic [LIM_W-1:0] mag;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (quo.ovf[w] || (quo.quo[w] > limit_reg))
            begin
                mag = limit_reg;
            end
            else
            begin
                mag = quo.quo[w];
            end
            rpm_next[w] = quo.neg[w] ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= quo.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rpm_reg <= rpm_next;
    end

    assign result_valid    = result_valid_reg;
    assign front_left_rpm  = rpm_reg[WHEEL_FL];
    assign front_right_rpm = rpm_reg[WHEEL_FR];
    assign rear_left_rpm   = rpm_reg[WHEEL_RL];
    assign rear_right_rpm  = rpm_reg[WHEEL_RR];

    always_comb
    begin
        out_in_range = 1'b1;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (($signed(rpm_reg[w]) > $signed({1'b0, limit_reg})) ||
                ($signed(rpm_reg[w]) < -$signed({1'b0, limit_reg})))
            begin
                out_in_range = 1'b0;
            end
        end
    end

    // Every accepted command yields a result strobe.
    a_cmd_answered: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##12 result_valid)
        else $error("accepted command produced no result word");

    // No strobe appears without a matching accepted command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(in_valid, 12))
        else $error("result word without a matching command");

    // Delivered wheel speeds never exceed the configured limit in magnitude.
    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_in_range)
        else $error("wheel speed outside the rpm limit");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for mecanum_inverse_kinematics: body velocity commands in,
// four clamped wheel speeds out, checked against an in-bench integer predictor.
// Depends on mik_pkg and the mecanum_inverse_kinematics RTL.
`timescale 1ns / 1ps

module tb_top;

    import mik_pkg::*;

    // Once the last command word is answered, the settle pause gives the pipeline
    // some margin before a register write or the verdict.
    localparam int PIPE_SETTLE    = 16;
    localparam int NUM_PHASES     = 9;
    localparam int RAND_PER_PHASE = 215;
    localparam int MAX_PRINTED    = 100;

    typedef logic signed [VEL_W-1:0] vel_t;
    typedef logic signed [RPM_W-1:0] rpm_t;
    typedef logic [NUM_WHEELS-1:0][RPM_W-1:0] wheel_rpm_t;

    localparam vel_t VEL_MAX = 16'sh7FFF;
    localparam vel_t VEL_MIN = 16'sh8000;

    // One body velocity command, as it crosses the command handshake.
    typedef struct packed {
        vel_t vx;
        vel_t vy;
        vel_t wz;
    } body_cmd_t;

    // The wheel speeds predicted for one command, kept with the command for messages.
    typedef struct packed {
        body_cmd_t  cmd;
        wheel_rpm_t rpm;
    } wheel_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    vel_t                   vel_x = '0;
    vel_t                   vel_y = '0;
    vel_t                   yaw_rate = '0;
    logic                   result_valid;
    rpm_t                   front_left_rpm;
    rpm_t                   front_right_rpm;
    rpm_t                   rear_left_rpm;
    rpm_t                   rear_right_rpm;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Commands waiting to be sent, and wheel speeds waiting to come back.
    body_cmd_t   cmd_q[$];
    wheel_word_t wheel_q[$];

    // Set at the edge that takes a command word; the driver clears it at the next
    // falling edge and retires the command from cmd_q.
    bit cmd_taken = 1'b0;

    int mismatch_count = 0;
    int sender_idle_pct = 0;

    // The predictor's own copy of the geometry registers, starting at their reset values.
    logic [CIRC_W-1:0] circ_mm   = 12'd314;
    logic [DIST_W-1:0] track_mm  = 12'd300;
    logic [DIST_W-1:0] base_mm   = 12'd300;
    logic [LIM_W-1:0]  limit_rpm = 15'd330;

    always #5 clk = ~clk;

    mecanum_inverse_kinematics i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .yaw_rate        (yaw_rate),
        .result_valid    (result_valid),
        .front_left_rpm  (front_left_rpm),
        .front_right_rpm (front_right_rpm),
        .rear_left_rpm   (rear_left_rpm),
        .rear_right_rpm  (rear_right_rpm),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // One wheel: exact quotient truncated toward zero, then the symmetric clamp.
    function automatic rpm_t clamp_rpm(input longint num, input longint divisor,
                                       input longint lim);
        longint q;
        q = num / divisor;
        if (q > lim)
        begin
            q = lim;
        end
        if (q < -lim)
        begin
            q = -lim;
        end
        return q[RPM_W-1:0];
    endfunction

    // Wheel speeds for one command under the current register copy. The
    // mixing signs follow the usual X-roller layout: the front-left and rear-right
    // wheels see the sideways term with the opposite sign to the other pair.
    function automatic wheel_rpm_t predict_wheels(input body_cmd_t c);
        longint     vx;
        longint     vy;
        longint     wz;
        longint     divisor;
        longint     lim;
        longint     lin_x;
        longint     lin_y;
        longint     turn;
        wheel_rpm_t r;
        vx = $signed(c.vx);
        vy = $signed(c.vy);
        wz = $signed(c.wz);
        // A circumference of zero is taken as one millimeter.
        divisor = (circ_mm == '0) ? 64'sd1000 : 64'sd1000 * longint'(circ_mm);
        lim = longint'(limit_rpm);
        lin_x = 60000 * vx;
        lin_y = 60000 * vy;
        turn = 30 * wz * (longint'(track_mm) + longint'(base_mm));
        r[WHEEL_FL] = clamp_rpm(lin_x - lin_y - turn, divisor, lim);
        r[WHEEL_FR] = clamp_rpm(lin_x + lin_y + turn, divisor, lim);
        r[WHEEL_RL] = clamp_rpm(lin_x + lin_y - turn, divisor, lim);
        r[WHEEL_RR] = clamp_rpm(lin_x - lin_y + turn, divisor, lim);
        return r;
    endfunction

    // Writes one register word and, once the block takes it, mirrors the write into
    // the predictor. Bits above a register's width are dropped, and an index that
    // names no register changes nothing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_CIRC:  circ_mm   = data[CIRC_W-1:0];
            REG_TRACK: track_mm  = data[DIST_W-1:0];
            REG_BASE:  base_mm   = data[DIST_W-1:0];
            REG_LIMIT: limit_rpm = data[LIM_W-1:0];
            default:   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued command has been sent and answered, then lets the
    // pipeline run empty.
    task automatic wait_for_drain();
        while (cmd_q.size() != 0 || start || wheel_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic push_cmd(input vel_t vx, input vel_t vy, input vel_t wz);
        body_cmd_t c;
        c.vx = vx;
        c.vy = vy;
        c.wz = wz;
        cmd_q.push_back(c);
    endtask

    function automatic vel_t near_zero();
        int v;
        v = int'($urandom_range(4000)) - 2000;
        return v[VEL_W-1:0];
    endfunction

    function automatic vel_t pick_extreme();
        case ($urandom_range(3))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            2:       return '0;
            default: return vel_t'($urandom);
        endcase
    endfunction

    // Random command: full-range values mostly saturate, so a good share stays near
    // zero where the division and rounding toward zero are visible. Some commands are
    // pure forward motion, some sit on the field extremes.
    function automatic body_cmd_t random_cmd();
        body_cmd_t   c;
        int unsigned kind;
        kind = $urandom_range(9);
        c.vx = vel_t'($urandom);
        c.vy = vel_t'($urandom);
        c.wz = vel_t'($urandom);
        if (kind >= 4 && kind <= 7)
        begin
            c.vx = near_zero();
            c.vy = near_zero();
            c.wz = near_zero();
        end
        else if (kind == 8)
        begin
            c.vx = near_zero();
            c.vy = '0;
            c.wz = '0;
        end
        else if (kind == 9)
        begin
            c.vx = pick_extreme();
            c.vy = pick_extreme();
            c.wz = pick_extreme();
        end
        return c;
    endfunction

    // Driver. Inputs change on the falling edge only. A command word stays on the
    // ports with start high until the block takes it; between words the fields carry
    // random noise with start low.
    always @(negedge clk)
    begin : drive_cmds
        bit was_taken;
        was_taken = cmd_taken;
        cmd_taken = 1'b0;
        if (was_taken)
        begin
            void'(cmd_q.pop_front());
        end
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !was_taken)
        begin
            // Still waiting for the block to take the current word.
        end
        else if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
        begin
            start    <= 1'b1;
            vel_x    <= cmd_q[0].vx;
            vel_y    <= cmd_q[0].vy;
            yaw_rate <= cmd_q[0].wz;
        end
        else
        begin
            start    <= 1'b0;
            vel_x    <= vel_t'($urandom);
            vel_y    <= vel_t'($urandom);
            yaw_rate <= vel_t'($urandom);
        end
    end

    // Monitor. On each rising edge it first checks a result word against the oldest
    // prediction, then records a command word taken at the same edge. The fixed
    // latency means a command can never be answered at the edge that takes it.
    always @(posedge clk)
    begin : watch_ports
        wheel_word_t exp_word;
        wheel_rpm_t  got;
        body_cmd_t   seen;
        string       wname;
        if (rst_n && result_valid)
        begin
            got[WHEEL_FL] = front_left_rpm;
            got[WHEEL_FR] = front_right_rpm;
            got[WHEEL_RL] = rear_left_rpm;
            got[WHEEL_RR] = rear_right_rpm;
            if (wheel_q.size() == 0)
            begin
                report_mismatch($sformatf("result word with no command pending: %0d %0d %0d %0d",
                    front_left_rpm, front_right_rpm, rear_left_rpm, rear_right_rpm));
            end
            else
            begin
                exp_word = wheel_q.pop_front();
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    case (w)
                        WHEEL_FL: wname = "front_left_rpm";
                        WHEEL_FR: wname = "front_right_rpm";
                        WHEEL_RL: wname = "rear_left_rpm";
                        default:  wname = "rear_right_rpm";
                    endcase
                    if (got[w] !== exp_word.rpm[w])
                    begin
                        report_mismatch($sformatf(
                            "%s got %0d expected %0d (vx %0d vy %0d wz %0d)",
                            wname, $signed(got[w]), $signed(exp_word.rpm[w]),
                            $signed(exp_word.cmd.vx), $signed(exp_word.cmd.vy),
                            $signed(exp_word.cmd.wz)));
                    end
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            seen.vx = vel_x;
            seen.vy = vel_y;
            seen.wz = yaw_rate;
            exp_word.cmd = seen;
            exp_word.rpm = predict_wheels(seen);
            wheel_q.push_back(exp_word);
            cmd_taken = 1'b1;
        end
    end

    // Sequencer. Phase 0 runs at the reset register values with the directed
    // commands first; each later phase changes the geometry while the block is idle.
    // The sender idles at a different rate from phase to phase.
    initial
    begin : run_phases
        int phase;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_drain();
                case (phase)
                    1:
                    begin
                        // Smallest wheel with the widest frame and the highest limit.
                        write_reg(REG_CIRC, 16'd1);
                        write_reg(REG_TRACK, 16'd4095);
                        write_reg(REG_BASE, 16'd4095);
                        write_reg(REG_LIMIT, 16'd32767);
                    end
                    2:
                    begin
                        // All-ones circ and limit: only each register's width is kept.
                        write_reg(REG_CIRC, 16'hFFFF);
                        write_reg(REG_TRACK, 16'd0);
                        write_reg(REG_BASE, 16'd0);
                        write_reg(REG_LIMIT, 16'hFFFF);
                    end
                    3:
                    begin
                        // Zero circumference acts as 1 mm; a zero limit pins every wheel.
                        write_reg(REG_CIRC, 16'd0);
                        write_reg(REG_TRACK, 16'd4095);
                        write_reg(REG_BASE, 16'hF000);
                        write_reg(REG_LIMIT, 16'd0);
                    end
                    4:
                    begin
                        // Back to the reset geometry, with writes to indexes that
                        // name no register in between.
                        write_reg(REG_CIRC, 16'd314);
                        write_reg(8'hFF, 16'hFFFF);
                        write_reg(REG_TRACK, 16'd300);
                        write_reg(REG_BASE, 16'd300);
                        write_reg(8'(int'(REG_LIMIT) + 1), 16'h0000);
                        write_reg(REG_LIMIT, 16'd330);
                    end
                    default:
                    begin
                        write_reg(REG_CIRC, CFG_DATA_W'($urandom));
                        write_reg(REG_TRACK, CFG_DATA_W'($urandom));
                        write_reg(REG_BASE, CFG_DATA_W'($urandom));
                        write_reg(REG_LIMIT, CFG_DATA_W'($urandom));
                        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                  int'(REG_LIMIT) + 1)), CFG_DATA_W'($urandom));
                    end
                endcase
            end
            case (phase % 4)
                1:       sender_idle_pct = 68;
                3:       sender_idle_pct = 22;
                default: sender_idle_pct = 0;
            endcase
            if (phase == 0)
            begin
                // Field extremes, sign mixes, rounding toward zero and the clamp edge:
                // 1727 mm/s forward lands exactly on 330 rpm at the reset geometry.
                push_cmd(0, 0, 0);
                push_cmd(VEL_MAX, 0, 0);
                push_cmd(VEL_MIN, 0, 0);
                push_cmd(0, VEL_MAX, 0);
                push_cmd(0, VEL_MIN, 0);
                push_cmd(0, 0, VEL_MAX);
                push_cmd(0, 0, VEL_MIN);
                push_cmd(VEL_MAX, VEL_MAX, VEL_MAX);
                push_cmd(VEL_MIN, VEL_MIN, VEL_MIN);
                push_cmd(VEL_MAX, VEL_MIN, VEL_MAX);
                push_cmd(VEL_MIN, VEL_MAX, VEL_MIN);
                push_cmd(1, 0, 0);
                push_cmd(-1, -1, -1);
                push_cmd(100, -50, 200);
                push_cmd(-1000, 500, -300);
                push_cmd(1727, 0, 0);
                push_cmd(1728, 0, 0);
                push_cmd(-1728, 0, 0);
                push_cmd(0, 1727, 0);
                push_cmd(0, 0, 5233);
            end
            repeat (RAND_PER_PHASE) cmd_q.push_back(random_cmd());
        end
        wait_for_drain();
        if (mismatch_count == 0)
        begin
            $display("mecanum_inverse_kinematics: match");
        end
        else
        begin
            $display("mecanum_inverse_kinematics: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("mecanum_inverse_kinematics: mismatch");
        $finish;
    end

endmodule
